### src/pn2d_pkg.sv
package pn2d_pkg;
  localparam int TABLE_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int TAB_BITS       = 8;
  localparam int COORD_W        = 24;
  localparam int NOISE_W        = 16;
  localparam int Q16_ONE        = 65536;
  localparam int CELL_MOD       = 255;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  // integer part reduced mod 255 by folding bytes (256 == 1 mod 255)
  function automatic logic [7:0] mod255(input logic [23:0] v);
    logic [9:0] s;
    logic [8:0] s2;
    begin
      s  = {2'b0, v[23:16]} + {2'b0, v[15:8]} + {2'b0, v[7:0]};
      s2 = {1'b0, s[7:0]} + {7'd0, s[9:8]};
      if (s2 >= 9'(CELL_MOD)) s2 = s2 - 9'(CELL_MOD);
      mod255 = s2[7:0];
    end
  endfunction

  // dot product of diagonal gradient with offset (dx, dy), Q.16, range +-2
  function automatic logic signed [18:0] grad_dot(input logic [1:0] sel,
                                                   input logic signed [17:0] dx,
                                                   input logic signed [17:0] dy);
    logic signed [18:0] a;
    logic signed [18:0] b;
    begin
      a = 19'(dx);
      b = 19'(dy);
      case (sel)
        2'd0:    grad_dot = a + b;
        2'd1:    grad_dot = b - a;
        2'd2:    grad_dot = -a - b;
        default: grad_dot = a - b;
      endcase
    end
  endfunction
endpackage

### src/perlin_noise_2d_unit.sv
// 2-D gradient noise, one word in and one result per cycle when not stalled.
// Load words (command=0) write a byte of the 256-entry permutation table and
// give no result; evaluate words (command=1) give one signed Q1.14 noise word.
// An evaluate passes through nine register stages, s1 to s8 and the output
// register, before its result can be taken at the output. A stalled
// result freezes the whole pipeline and stalls the input. The table sits in
// three copies of a 256x8 synchronous memory, each read at two addresses a
// cycle: one for the first lookup and one each for the left and right corner
// lookups; loads are written to all three. A table entry read before it was
// ever loaded gives an undefined result. Each lookup reads the table at the
// edge where the evaluate moves on, so loads accepted before an evaluate are
// seen by it and loads accepted after it are not.
module perlin_noise_2d_unit
  import pn2d_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      command,
  input  logic [TAB_BITS-1:0]       table_index,
  input  logic [TAB_BITS-1:0]       table_value,
  input  logic [COORD_W-1:0]        coord_x,
  input  logic [COORD_W-1:0]        coord_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [NOISE_W-1:0] noise_value
);
  localparam int NST = 9;
  localparam int SH  = 16 - FRAC_BITS;

  logic [NST-1:0] v;
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  logic acc;
  assign acc = in_valid && adv;

  logic [7:0] mem_a [TABLE_SIZE];
  logic [7:0] mem_b [TABLE_SIZE];
  logic [7:0] mem_c [TABLE_SIZE];

  // load write
  logic       we;
  logic [7:0] wa, wd;
  assign we = acc && (command == CMD_LOAD);
  assign wa = table_index;
  assign wd = table_value;

  // stage 0: address prep
  logic [7:0]  xi0, yi0;
  logic [16:0] tx0, ty0;
  always_comb begin
    xi0 = mod255(coord_x >> FRAC_BITS);
    yi0 = mod255(coord_y >> FRAC_BITS);
    tx0 = 17'(coord_x[FRAC_BITS-1:0]) << SH;
    ty0 = 17'(coord_y[FRAC_BITS-1:0]) << SH;
  end

  // s1: first lookup registered
  logic [7:0]  pl1, pr1, yi1;
  logic [16:0] tx1, ty1;
  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[wa] <= wd;
      mem_b[wa] <= wd;
      mem_c[wa] <= wd;
    end
    if (adv) begin
      pl1 <= mem_a[xi0];
      pr1 <= mem_a[xi0 + 8'd1];
      yi1 <= yi0;
      tx1 <= tx0;
      ty1 <= ty0;
    end
  end

  logic [7:0] ab, at, ar, art;
  assign ab  = pl1 + yi1;
  assign at  = pl1 + yi1 + 8'd1;
  assign ar  = pr1 + yi1;
  assign art = pr1 + yi1 + 8'd1;

  // s2: second lookup
  logic [7:0]  gb2, gt2, gr2, grt2;
  logic [16:0] tx2, ty2;
  always_ff @(posedge clk) begin
    if (adv) begin
      gb2  <= mem_b[ab];
      gt2  <= mem_b[at];
      gr2  <= mem_c[ar];
      grt2 <= mem_c[art];
      tx2 <= tx1;
      ty2 <= ty1;
    end
  end
  logic [1:0] sb, st, sr, srt;
  assign sb  = gb2[1:0];
  assign st  = gt2[1:0];
  assign sr  = gr2[1:0];
  assign srt = grt2[1:0];

  logic signed [17:0] dx0, dx1, dy0, dy1;
  assign dx0 = 18'(tx2);
  assign dy0 = 18'(ty2);
  assign dx1 = 18'(tx2) - 18'(Q16_ONE);
  assign dy1 = 18'(ty2) - 18'(Q16_ONE);

  // s3: dots, t^2 for fades
  logic signed [18:0] dbl3, dtl3, dbr3, dtr3;
  logic [16:0] tx3, ty3;
  logic [16:0] tx23, ty23;
  logic [33:0] px, py;
  assign px = tx2 * tx2;
  assign py = ty2 * ty2;
  always_ff @(posedge clk) begin
    if (adv) begin
      dbl3 <= grad_dot(sb, dx0, dy0);
      dtl3 <= grad_dot(st, dx0, dy1);
      dbr3 <= grad_dot(sr, dx1, dy0);
      dtr3 <= grad_dot(srt, dx1, dy1);
      tx3 <= tx2; ty3 <= ty2;
      tx23 <= 17'(px >> 16);
      ty23 <= 17'(py >> 16);
    end
  end

  // s4: t3 and p
  logic signed [18:0] dbl4, dtl4, dbr4, dtr4;
  logic [16:0] tx34, ty34;
  logic signed [20:0] ppx4, ppy4;
  logic [33:0] qx, qy;
  assign qx = tx23 * tx3;
  assign qy = ty23 * ty3;
  always_ff @(posedge clk) begin
    if (adv) begin
      dbl4 <= dbl3; dtl4 <= dtl3; dbr4 <= dbr3; dtr4 <= dtr3;
      tx34 <= 17'(qx >> 16);
      ty34 <= 17'(qy >> 16);
      ppx4 <= 21'(6 * tx23) - 21'(15 * tx3) + 21'(10 * Q16_ONE);
      ppy4 <= 21'(6 * ty23) - 21'(15 * ty3) + 21'(10 * Q16_ONE);
    end
  end

  // s5: fade values
  logic signed [18:0] dbl5, dtl5, dbr5, dtr5;
  logic [15:0] u5, w5;
  logic signed [38:0] fx, fy;
  logic signed [22:0] fxs, fys;
  assign fx  = $signed({1'b0, tx34}) * ppx4;
  assign fy  = $signed({1'b0, ty34}) * ppy4;
  assign fxs = 23'(fx >>> 16);
  assign fys = 23'(fy >>> 16);
  always_ff @(posedge clk) begin
    if (adv) begin
      dbl5 <= dbl4; dtl5 <= dtl4; dbr5 <= dbr4; dtr5 <= dtr4;
      u5 <= (fxs < 0) ? 16'd0 : (fxs > 23'sd65535) ? 16'hFFFF : fxs[15:0];
      w5 <= (fys < 0) ? 16'd0 : (fys > 23'sd65535) ? 16'hFFFF : fys[15:0];
    end
  end

  // s6: y blends, product
  logic signed [19:0] el, er;
  assign el = 20'(dtl5) - 20'(dbl5);
  assign er = 20'(dtr5) - 20'(dbr5);
  logic signed [36:0] ml6, mr6;
  logic signed [18:0] bl6, br6;
  logic [15:0] u6;
  always_ff @(posedge clk) begin
    if (adv) begin
      ml6 <= el * $signed({1'b0, w5});
      mr6 <= er * $signed({1'b0, w5});
      bl6 <= dbl5; br6 <= dbr5; u6 <= u5;
    end
  end

  // s7: left/right values
  logic signed [19:0] l7, r7;
  logic [15:0] u7;
  always_ff @(posedge clk) begin
    if (adv) begin
      l7 <= 20'(bl6) + 20'(ml6 >>> 16);
      r7 <= 20'(br6) + 20'(mr6 >>> 16);
      u7 <= u6;
    end
  end

  // s8: x blend product
  logic signed [20:0] ex;
  assign ex = 21'(r7) - 21'(l7);
  logic signed [37:0] m8;
  logic signed [19:0] l8;
  always_ff @(posedge clk) begin
    if (adv) begin
      m8 <= ex * $signed({1'b0, u7});
      l8 <= l7;
    end
  end

  // output: shift to Q1.14 and saturate
  logic signed [21:0] rq, r14;
  assign rq  = 22'(l8) + 22'(m8 >>> 16);
  assign r14 = rq >>> 2;
  always_ff @(posedge clk) begin
    if (adv) begin
      noise_value <= (r14 > 22'sd32767) ? 16'sh7FFF :
                     (r14 < -22'sd32768) ? 16'sh8000 : r14[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NST-2:0], acc && (command == CMD_EVAL)};
    end
  end
  assign out_valid = v[NST-1];
endmodule

### src/pn2d_checker.sv
module pn2d_checker
  import pn2d_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [NOISE_W-1:0] noise_value
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(noise_value))
    else $error("stalled result changed");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
  a_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(noise_value))
    else $error("unknown result word");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("valid after reset");
endmodule

bind perlin_noise_2d_unit pn2d_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .noise_value(noise_value)
);
